/* hdl/pbrm_pkg.sv */
`timescale 1ns / 1ps

package pbrm_pkg;

    localparam int PAGES_DEF     = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam int IN_W     = 12;
    localparam int NEXT_W   = 13;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED = 2'd0,
        ST_REJECT  = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_DIV3,
        S_CHECK,
        S_FILL,
        S_FILL_END,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic set_reject;
        logic fill_init;
        logic fill_read;
        logic ptr_min;
        logic scan_init;
        logic scan_read;
        logic scan_take;
        logic scan_full;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic range_ok;
        logic fill_rd_last;
        logic mark;
        logic ptr_eq_first;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

/* hdl/page_bitmap_range_marker.sv */
`timescale 1ns / 1ps

// channel   | dir | tdata (low bit up)                  | tuser
// ----------+-----+-------------------------------------+------------------------
// s_ range  | in  | first_page[11:0], end_page[23:12]   | mark_free
// m_ result | out | next_free[12:0], zero pad [15:13]   | status[1:0]
//
// one item at a time; after its accept cycle an item passes the division steps and a range
// check; a rejected item then goes to the result, an applied one reads and rewrites each
// bitmap word the range covers, and a pointer scan may then read words up to the map's end
// after reset a clearing pass writes (PAGES+WORD_BITS-1)/WORD_BITS words with s_tready low
// a finished result waits in the output register while the next item is taken; that
// item holds in its last cycle until the output register is free

module page_bitmap_range_marker #(
    parameter int PAGES     = pbrm_pkg::PAGES_DEF,
    parameter int WORD_BITS = pbrm_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pbrm_pkg::S_DATA_W-1:0] s_tdata,  // first_page, end_page
    input  logic                          s_tuser,  // mark_free
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbrm_pkg::M_DATA_W-1:0] m_tdata,  // next_free
    output logic [pbrm_pkg::STATUS_W-1:0] m_tuser   // status
);

    pbrm_pkg::cmd_t cmd;
    pbrm_pkg::sts_t sts;

    pbrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbrm_datapath #(
        .PAGES     (PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hdl/pbrm_ram.sv */
`timescale 1ns / 1ps

module pbrm_ram #(
    parameter int WIDTH = pbrm_pkg::WORD_BITS_DEF,
    parameter int DEPTH = pbrm_pkg::PAGES_DEF / pbrm_pkg::WORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/pbrm_ctrl.sv */
`timescale 1ns / 1ps

module pbrm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pbrm_pkg::sts_t sts,
    output pbrm_pkg::cmd_t cmd
);

    pbrm_pkg::state_t state_reg;
    pbrm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbrm_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbrm_pkg::S_CLEAR: begin
                if (sts.clear_last) state_next = pbrm_pkg::S_IDLE;
            end
            pbrm_pkg::S_IDLE: begin
                if (s_tvalid) state_next = pbrm_pkg::S_DIV1;
            end
            pbrm_pkg::S_DIV1: state_next = pbrm_pkg::S_DIV2;
            pbrm_pkg::S_DIV2: state_next = pbrm_pkg::S_DIV3;
            pbrm_pkg::S_DIV3: state_next = pbrm_pkg::S_CHECK;
            pbrm_pkg::S_CHECK: begin
                state_next = sts.range_ok ? pbrm_pkg::S_FILL : pbrm_pkg::S_DONE;
            end
            pbrm_pkg::S_FILL: begin
                if (sts.fill_rd_last) state_next = pbrm_pkg::S_FILL_END;
            end
            pbrm_pkg::S_FILL_END: begin
                if (!sts.mark && sts.ptr_eq_first) begin
                    state_next = pbrm_pkg::S_SCAN;
                end else begin
                    state_next = pbrm_pkg::S_DONE;
                end
            end
            pbrm_pkg::S_SCAN: begin
                if (sts.scan_hit || sts.scan_end) state_next = pbrm_pkg::S_DONE;
            end
            pbrm_pkg::S_DONE: begin
                if (sts.out_free) state_next = pbrm_pkg::S_IDLE;
            end
            default: state_next = pbrm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            pbrm_pkg::S_CLEAR: cmd.clear_step = 1'b1;
            pbrm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            pbrm_pkg::S_CHECK: begin
                cmd.fill_init  = sts.range_ok;
                cmd.set_reject = !sts.range_ok;
            end
            pbrm_pkg::S_FILL: cmd.fill_read = 1'b1;
            pbrm_pkg::S_FILL_END: begin
                cmd.ptr_min   = sts.mark;
                cmd.scan_init = !sts.mark && sts.ptr_eq_first;
            end
            pbrm_pkg::S_SCAN: begin
                cmd.scan_read = 1'b1;
                cmd.scan_take = sts.scan_hit;
                cmd.scan_full = sts.scan_end;
            end
            pbrm_pkg::S_DONE: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hdl/pbrm_datapath.sv */
`timescale 1ns / 1ps

module pbrm_datapath #(
    parameter int PAGES     = pbrm_pkg::PAGES_DEF,
    parameter int WORD_BITS = pbrm_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pbrm_pkg::cmd_t                cmd,
    output pbrm_pkg::sts_t                sts,
    input  logic [pbrm_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbrm_pkg::M_DATA_W-1:0] m_tdata,
    output logic [pbrm_pkg::STATUS_W-1:0] m_tuser
);

    localparam int IN_W   = pbrm_pkg::IN_W;
    localparam int WC     = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (WC > 1) ? $clog2(WC) : 1;
    localparam int CW     = $clog2(WC + 1);
    localparam int PW     = $clog2(PAGES + 1);
    localparam int EW     = (PW > IN_W) ? PW : IN_W;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int DIV_SH = IN_W + 4;
    localparam int RECIP  = (1 << DIV_SH) / WORD_BITS;
    localparam int MW     = IN_W + DIV_SH;

    localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};
    localparam logic [BW:0]          WB_HI = (BW + 1)'(WORD_BITS);
    localparam logic [CW-1:0]        WLAST = CW'(WC - 1);

    // captured item
    logic [IN_W-1:0] first_reg, last_reg;
    logic            mark_reg;

    // word / bit split of both range ends, three registered steps
    logic [IN_W-1:0] fqe_reg, lqe_reg, fqe_next, lqe_next;
    logic [IN_W-1:0] fprod_reg, lprod_reg, fprod_next, lprod_next;
    logic [CW-1:0]   fq_reg, lq_reg, fq_next, lq_next;
    logic [BW-1:0]   fr_reg, lr_reg, fr_next, lr_next;
    logic [MW-1:0]   fmul, lmul;
    logic [IN_W-1:0] frem, lrem;

    // word walk
    logic [CW-1:0]   rd_word_reg, rd_word_next;
    logic [CW-1:0]   wr_word_reg, wr_word_next;
    logic            fpend_reg, fpend_next;
    logic            spend_reg, spend_next;
    logic            sfirst_reg, sfirst_next;
    logic [PW-1:0]   sbase_reg, sbase_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    pbrm_pkg::status_t status_reg, status_next;

    logic                          mvalid_reg, mvalid_next;
    logic [pbrm_pkg::M_DATA_W-1:0] mdata_reg, mdata_next;
    logic [pbrm_pkg::STATUS_W-1:0] muser_reg, muser_next;

    // last word touched by the fill and its exclusive top bit
    logic [CW-1:0]        lw_word;
    logic [BW:0]          lw_hi;
    logic [BW-1:0]        lo_bit;
    logic [BW:0]          hi_bit;
    logic [WORD_BITS-1:0] fmask, fdata;
    logic [WORD_BITS-1:0] smask, sdata, slow;
    logic [BW-1:0]        sidx;
    logic                 issue_ok;

    logic                 ram_wr_en, ram_rd_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

    pbrm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WC)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_word_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // reciprocal estimate is exact or one low, fixed up in the third step
    always_comb begin
        fmul       = MW'(first_reg) * MW'(RECIP);
        lmul       = MW'(last_reg) * MW'(RECIP);
        fqe_next   = IN_W'(fmul >> DIV_SH);
        lqe_next   = IN_W'(lmul >> DIV_SH);
        fprod_next = IN_W'((IN_W + 8)'(fqe_reg) * (IN_W + 8)'(WORD_BITS));
        lprod_next = IN_W'((IN_W + 8)'(lqe_reg) * (IN_W + 8)'(WORD_BITS));
        frem       = first_reg - fprod_reg;
        lrem       = last_reg - lprod_reg;
        if (frem >= IN_W'(WORD_BITS)) begin
            fq_next = CW'(fqe_reg + IN_W'(1));
            fr_next = BW'(frem - IN_W'(WORD_BITS));
        end else begin
            fq_next = CW'(fqe_reg);
            fr_next = BW'(frem);
        end
        if (lrem >= IN_W'(WORD_BITS)) begin
            lq_next = CW'(lqe_reg + IN_W'(1));
            lr_next = BW'(lrem - IN_W'(WORD_BITS));
        end else begin
            lq_next = CW'(lqe_reg);
            lr_next = BW'(lrem);
        end
    end

    always_comb begin
        if (lr_reg == '0) begin
            lw_word = lq_reg - CW'(1);
            lw_hi   = WB_HI;
        end else begin
            lw_word = lq_reg;
            lw_hi   = (BW + 1)'(lr_reg);
        end
        lo_bit = (wr_word_reg == fq_reg) ? fr_reg : '0;
        hi_bit = (wr_word_reg == lw_word) ? lw_hi : WB_HI;
        fmask  = (ONES << lo_bit) & (ONES >> (WB_HI - hi_bit));
        fdata  = mark_reg ? (ram_rd_data | fmask) : (ram_rd_data & ~fmask);

        smask = sfirst_reg ? (ONES << lr_reg) : ONES;
        sdata = ram_rd_data & smask;
        slow  = sdata & (~sdata + WORD_BITS'(1));
        sidx  = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (slow[i]) sidx = sidx | BW'(i);
        end
    end

    assign issue_ok = (rd_word_reg < CW'(WC));

    always_comb begin
        ram_wr_en   = cmd.clear_step | fpend_reg;
        ram_wr_addr = cmd.clear_step ? rd_word_reg[AW-1:0] : wr_word_reg[AW-1:0];
        ram_wr_data = cmd.clear_step ? '0 : fdata;
        ram_rd_en   = cmd.fill_read | (cmd.scan_read & issue_ok);
    end

    always_comb begin
        rd_word_next = rd_word_reg;
        wr_word_next = wr_word_reg;
        fpend_next   = cmd.fill_read;
        spend_next   = cmd.scan_read & issue_ok;
        sfirst_next  = sfirst_reg;
        sbase_next   = sbase_reg;
        ptr_next     = ptr_reg;
        status_next  = status_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;

        if (cmd.clear_step) rd_word_next = rd_word_reg + CW'(1);
        if (cmd.load) status_next = pbrm_pkg::ST_APPLIED;
        if (cmd.set_reject) status_next = pbrm_pkg::ST_REJECT;
        if (cmd.fill_init) rd_word_next = fq_reg;
        if (cmd.fill_read) begin
            rd_word_next = rd_word_reg + CW'(1);
            wr_word_next = rd_word_reg;
        end
        if (cmd.ptr_min && (EW'(first_reg) < EW'(ptr_reg))) begin
            ptr_next = PW'(first_reg);
        end
        if (cmd.scan_init) begin
            ptr_next     = PW'(last_reg);
            rd_word_next = lq_reg;
            sbase_next   = PW'(last_reg) - PW'(lr_reg);
            sfirst_next  = 1'b1;
        end
        if (cmd.scan_read) begin
            if (issue_ok) begin
                rd_word_next = rd_word_reg + CW'(1);
                wr_word_next = rd_word_reg;
            end
            if (spend_reg) begin
                sbase_next  = sbase_reg + PW'(WORD_BITS);
                sfirst_next = 1'b0;
            end
        end
        if (cmd.scan_take) ptr_next = sbase_reg + PW'(sidx);
        if (cmd.scan_full) begin
            ptr_next    = PW'(PAGES);
            status_next = pbrm_pkg::ST_FULL;
        end

        if (m_tready) mvalid_next = 1'b0;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
            mdata_next  = pbrm_pkg::M_DATA_W'(pbrm_pkg::NEXT_W'(ptr_reg));
            muser_next  = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_word_reg <= '0;
            fpend_reg   <= 1'b0;
            spend_reg   <= 1'b0;
            sfirst_reg  <= 1'b0;
            ptr_reg     <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            rd_word_reg <= rd_word_next;
            fpend_reg   <= fpend_next;
            spend_reg   <= spend_next;
            sfirst_reg  <= sfirst_next;
            ptr_reg     <= ptr_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            first_reg <= s_tdata[IN_W-1:0];
            last_reg  <= s_tdata[2*IN_W-1:IN_W];
            mark_reg  <= s_tuser;
        end
        fqe_reg     <= fqe_next;
        lqe_reg     <= lqe_next;
        fprod_reg   <= fprod_next;
        lprod_reg   <= lprod_next;
        fq_reg      <= fq_next;
        lq_reg      <= lq_next;
        fr_reg      <= fr_next;
        lr_reg      <= lr_next;
        wr_word_reg <= wr_word_next;
        sbase_reg   <= sbase_next;
        status_reg  <= status_next;
        mdata_reg   <= mdata_next;
        muser_reg   <= muser_next;
    end

    always_comb begin
        sts.clear_last   = (rd_word_reg == WLAST);
        sts.range_ok     = (first_reg < last_reg) && (32'(last_reg) < 32'(PAGES));
        sts.fill_rd_last = (rd_word_reg == lw_word);
        sts.mark         = mark_reg;
        sts.ptr_eq_first = (EW'(ptr_reg) == EW'(first_reg));
        sts.scan_hit     = spend_reg && (sdata != '0);
        sts.scan_end     = spend_reg && (sdata == '0) && (wr_word_reg == WLAST);
        sts.out_free     = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

/* dv/page_bitmap_range_marker_checker.sv */
`timescale 1ns / 1ps

module page_bitmap_range_marker_checker
    import pbrm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0] m_tuser,
    output int                  mismatches,
    output int                  pending,
    output logic [NEXT_W-1:0]   pointer_now
);

    localparam int PAGES = PAGES_DEF;

    typedef struct packed {
        logic [NEXT_W-1:0] next_free;
        status_t           status;
    } range_result_t;

    logic [PAGES-1:0]  free_map;
    logic [NEXT_W-1:0] free_ptr;
    range_result_t     owed_results[$];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // marks the range in the page map and moves the first-free pointer
    function automatic range_result_t apply_range(input logic [IN_W-1:0] first,
                                                  input logic [IN_W-1:0] end_pg,
                                                  input logic mark);
        range_result_t res;
        res.status = ST_APPLIED;
        if (first >= end_pg || int'(first) >= PAGES || int'(end_pg) >= PAGES) begin
            res.status = ST_REJECT;
        end else begin
            for (int p = int'(first); p < int'(end_pg); p++) free_map[IN_W'(p)] = mark;
            if (mark) begin
                if (first < free_ptr) free_ptr = NEXT_W'(first);
            end else if (free_ptr == first) begin
                free_ptr = NEXT_W'(end_pg);
                while (free_ptr < PAGES && !free_map[free_ptr[IN_W-1:0]]) free_ptr++;
                if (free_ptr >= PAGES) res.status = ST_FULL;
            end
        end
        res.next_free = free_ptr;
        return res;
    endfunction

    always @(posedge aclk) begin
        range_result_t want;
        if (!aresetn) begin
            free_map = '0;
            free_ptr = '0;
            mismatches = 0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                owed_results.push_back(apply_range(s_tdata[IN_W-1:0],
                                                   s_tdata[2*IN_W-1:IN_W], s_tuser));
            end
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed: next_free %0d",
                                              m_tdata));
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata != M_DATA_W'(want.next_free))
                        report_mismatch($sformatf("next_free got %0d, expected %0d",
                                                  m_tdata, want.next_free));
                    if (m_tuser != want.status)
                        report_mismatch($sformatf("status got %0d, expected %s",
                                                  m_tuser, want.status.name()));
                end
            end
        end
        pending = owed_results.size();
        pointer_now = free_ptr;
    end

endmodule

/* dv/page_bitmap_range_marker_test.sv */
`timescale 1ns / 1ps

module page_bitmap_range_marker_test;
    import pbrm_pkg::*;

    localparam int LAST_PAGE = PAGES_DEF - 1;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int                send_idle_pct = 27;
    int                recv_idle_pct = 78;
    int                mismatches;
    int                pending;
    logic [NEXT_W-1:0] pointer_now;

    always #5 aclk = ~aclk;

    page_bitmap_range_marker i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    page_bitmap_range_marker_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .pointer_now(pointer_now)
    );

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_range(input logic [IN_W-1:0] first, input logic [IN_W-1:0] end_pg,
                              input logic mark);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {end_pg, first};
        s_tuser  = mark;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // mostly well-formed ranges; a share start at the free pointer to drive the scan
    task automatic send_random_range();
        logic [IN_W-1:0] first;
        logic [IN_W-1:0] end_pg;
        logic            mark;
        int              kind;
        int              span;
        int              top_len;
        kind = $urandom_range(99);
        span = ($urandom_range(29) == 0) ? LAST_PAGE : 96;
        if (kind < 8) begin
            first  = IN_W'($urandom_range(LAST_PAGE));
            end_pg = IN_W'($urandom_range(first));
            mark   = 1'($urandom_range(1));
        end else begin
            if (kind < 40 && pointer_now < LAST_PAGE) begin
                first = pointer_now[IN_W-1:0];
                mark  = 1'b0;
            end else begin
                first = IN_W'($urandom_range(LAST_PAGE - 1));
                mark  = (kind < 75);
            end
            top_len = LAST_PAGE - int'(first);
            if (top_len > span) top_len = span;
            end_pg = first + IN_W'($urandom_range(top_len, 1));
        end
        send_range(first, end_pg, mark);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // all used after reset, so the scan runs off the top
        send_range(0, 1, 1'b0);
        send_range(0, 0, 1'b1);
        send_range(LAST_PAGE, LAST_PAGE, 1'b1);
        send_range(LAST_PAGE, 0, 1'b0);
        send_range(100, 200, 1'b1);
        send_range(50, 100, 1'b0);
        send_range(100, 150, 1'b0);
        send_range(150, 200, 1'b0);
        // whole map: the last page is never reached through end_page
        send_range(0, LAST_PAGE, 1'b1);
        send_range(0, LAST_PAGE, 1'b0);
        send_range(LAST_PAGE - 1, LAST_PAGE, 1'b1);
        send_range(LAST_PAGE - 1, LAST_PAGE, 1'b0);
        send_range(0, 64, 1'b1);
        send_range(0, 63, 1'b0);
        send_range(63, 64, 1'b0);
        send_range(3000, 3100, 1'b1);
        send_range(2000, 2001, 1'b1);
        send_range(5, 6, 1'b0);
        send_range(2000, 2001, 1'b0);
        send_range(3000, 2999, 1'b1);
        send_range(1, LAST_PAGE, 1'b1);
        send_range(1, 2, 1'b0);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (545) send_random_range();
            wait_for_results();
        end

        repeat (200) @(negedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/pbrm_pkg.sv
hdl/pbrm_ram.sv
hdl/pbrm_ctrl.sv
hdl/pbrm_datapath.sv
hdl/page_bitmap_range_marker.sv
dv/page_bitmap_range_marker_checker.sv
dv/page_bitmap_range_marker_test.sv
